// ===== sv/bpr_pkg.sv =====
package bpr_pkg;

  localparam int MAX_WIDTH_DEF     = 16384;
  localparam int MAX_HEIGHT_DEF    = 16384;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_FORMAT     = 3'd0;
  localparam logic [2:0] REG_WIDTH      = 3'd1;
  localparam logic [2:0] REG_HEIGHT     = 3'd2;
  localparam logic [2:0] REG_RED_MASK   = 3'd3;
  localparam logic [2:0] REG_GREEN_MASK = 3'd4;
  localparam logic [2:0] REG_BLUE_MASK  = 3'd5;

  localparam logic [2:0]  FMT_1BPP   = 3'd0;
  localparam logic [2:0]  FMT_4BPP   = 3'd1;
  localparam logic [2:0]  FMT_8BPP   = 3'd2;
  localparam logic [2:0]  FMT_BGR24  = 3'd3;
  localparam logic [2:0]  FMT_MASK32 = 3'd4;

  localparam logic [2:0]  FORMAT_RST     = FMT_BGR24;
  localparam logic [14:0] WIDTH_RST      = 15'd1;
  localparam logic [14:0] HEIGHT_RST     = 15'd1;
  localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_PALETTE = 1'b1;

  typedef enum logic [1:0] {
    PIX_PAL,
    PIX_BGR,
    PIX_MASK
  } pix_kind_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [31:0] red_mask;
    logic [31:0] green_mask;
    logic [31:0] blue_mask;
    logic [31:0] alpha_mask;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic [4:0]  alpha_shift;
    logic        mask_err;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_item_t;

  typedef struct packed {
    pix_kind_t   kind;
    logic        pal_ok;
    logic [31:0] word;
    logic [13:0] column;
    logic [13:0] row;
    logic        last_run;
    logic        last_img;
  } pix_t;

  // position of the lowest set bit, zero for an empty mask
  function automatic logic [4:0] low_bit(input logic [31:0] m);
    logic [31:0] iso;
    logic [4:0]  res;
    iso = m & (~m + 32'd1);
    res = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) begin
        res = res | 5'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/bpr_in_if.sv =====
interface bpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;

  modport source (
    output valid, action, data_byte, palette_index, palette_red, palette_green,
           palette_blue,
    input  ready
  );

  modport sink (
    input  valid, action, data_byte, palette_index, palette_red, palette_green,
           palette_blue,
    output ready
  );
endinterface

// ===== sv/bpr_out_if.sv =====
interface bpr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [13:0] column;
  logic [13:0] row;
  logic        last_of_run;
  logic        last_of_image;
  logic        mask_error;

  modport source (
    output valid, red, green, blue, alpha, column, row, last_of_run, last_of_image,
           mask_error,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha, column, row, last_of_run, last_of_image,
           mask_error,
    output ready
  );
endinterface

// ===== sv/bpr_ram.sv =====
module bpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bpr_regs.sv =====
module bpr_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpr_pkg::CFG_AW-1:0]  paddr,
  input  logic [bpr_pkg::CFG_DW-1:0]  pwdata,
  output logic [bpr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output bpr_pkg::cfg_t               cfg
);

  logic [2:0]  format_r;
  logic [14:0] width_r;
  logic [14:0] height_r;
  logic [31:0] red_mask_r;
  logic [31:0] green_mask_r;
  logic [31:0] blue_mask_r;
  logic [31:0] alpha_mask_r;
  logic [4:0]  red_shift_r;
  logic [4:0]  green_shift_r;
  logic [4:0]  blue_shift_r;
  logic [4:0]  alpha_shift_r;
  logic        mask_err_r;
  logic [31:0] alpha_mask_nxt;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r     <= bpr_pkg::FORMAT_RST;
      width_r      <= bpr_pkg::WIDTH_RST;
      height_r     <= bpr_pkg::HEIGHT_RST;
      red_mask_r   <= bpr_pkg::RED_MASK_RST;
      green_mask_r <= bpr_pkg::GREEN_MASK_RST;
      blue_mask_r  <= bpr_pkg::BLUE_MASK_RST;
    end else if (wr) begin
      unique case (idx)
        bpr_pkg::REG_FORMAT:     format_r     <= pwdata[2:0];
        bpr_pkg::REG_WIDTH:      width_r      <= pwdata[14:0];
        bpr_pkg::REG_HEIGHT:     height_r     <= pwdata[14:0];
        bpr_pkg::REG_RED_MASK:   red_mask_r   <= pwdata;
        bpr_pkg::REG_GREEN_MASK: green_mask_r <= pwdata;
        bpr_pkg::REG_BLUE_MASK:  blue_mask_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // mask decode is derived state, refreshed every cycle
  assign alpha_mask_nxt = ~(red_mask_r | green_mask_r | blue_mask_r);

  always_ff @(posedge clk) begin
    alpha_mask_r  <= alpha_mask_nxt;
    red_shift_r   <= bpr_pkg::low_bit(red_mask_r);
    green_shift_r <= bpr_pkg::low_bit(green_mask_r);
    blue_shift_r  <= bpr_pkg::low_bit(blue_mask_r);
    alpha_shift_r <= bpr_pkg::low_bit(alpha_mask_nxt);
    mask_err_r    <= (red_mask_r == '0) || (green_mask_r == '0) ||
                     (blue_mask_r == '0) || (alpha_mask_nxt == '0);
  end

  always_comb begin
    unique case (idx)
      bpr_pkg::REG_FORMAT:     prdata = 32'(format_r);
      bpr_pkg::REG_WIDTH:      prdata = 32'(width_r);
      bpr_pkg::REG_HEIGHT:     prdata = 32'(height_r);
      bpr_pkg::REG_RED_MASK:   prdata = red_mask_r;
      bpr_pkg::REG_GREEN_MASK: prdata = green_mask_r;
      bpr_pkg::REG_BLUE_MASK:  prdata = blue_mask_r;
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pixel_format = format_r;
    cfg.image_width  = width_r;
    cfg.image_height = height_r;
    cfg.red_mask     = red_mask_r;
    cfg.green_mask   = green_mask_r;
    cfg.blue_mask    = blue_mask_r;
    cfg.alpha_mask   = alpha_mask_r;
    cfg.red_shift    = red_shift_r;
    cfg.green_shift  = green_shift_r;
    cfg.blue_shift   = blue_shift_r;
    cfg.alpha_shift  = alpha_shift_r;
    cfg.mask_err     = mask_err_r;
  end

endmodule

// ===== sv/bpr_emitter.sv =====
module bpr_emitter #(
  parameter int MAX_WIDTH     = bpr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = bpr_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bpr_in_if.sink                           in_ch,
  input  bpr_pkg::cfg_t                    cfg,
  input  logic                             pix_adv,
  output bpr_pkg::pix_t                    pix,
  output logic                             pix_valid,
  output logic                             pal_we,
  output logic [$clog2(PALETTE_DEPTH)-1:0] pal_waddr,
  output logic [23:0]                      pal_wdata,
  output logic                             pal_re,
  output logic [$clog2(PALETTE_DEPTH)-1:0] pal_raddr,
  output logic                             pal_vld
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int DW = CW + 3;
  localparam int XW = CW + 4;

  logic              in_valid_r;
  bpr_pkg::in_item_t in_item_r;
  logic              in_take;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [23:0]   asm_r, asm_nxt;
  logic          done_r, done_nxt;

  logic [2:0]    work_cnt_r, work_cnt_nxt;
  logic [2:0]    work_pos_r, work_pos_nxt;
  logic          work_nib_r, work_nib_nxt;
  logic [7:0]    work_byte_r, work_byte_nxt;

  bpr_pkg::pix_t pix_r, pix_nxt;
  logic          pix_valid_r, pix_valid_nxt;

  logic [PALETTE_DEPTH-1:0] vld_r;
  logic                     pal_vld_r;

  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [XW-1:0] wx;
  logic [XW-1:0] w_plus7;
  logic [XW-1:0] w_plus1;
  logic [1:0]    bytes_lo;
  logic [1:0]    pad_amt;

  logic              emit_ok;
  logic              do_emit;
  bpr_pkg::pix_kind_t e_kind;
  logic [31:0]       e_word;
  logic [7:0]        e_idx;
  logic              e_last_run;
  logic              e_last_img;
  logic              e_pal_ok;
  logic [CW-1:0]     c0;
  logic [RW-1:0]     r0;
  logic [CW-1:0]     c1;
  logic [RW-1:0]     r1;
  logic [DW-1:0]     diff;
  logic [3:0]        nrun;
  logic [CW:0]       c0_next;
  logic [RW-1:0]     row_out;

  always_comb begin
    if (cfg.image_width == '0) begin
      w = CW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = RW'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(cfg.image_height);
    end
  end

  // stored row length modulo four, for the padding count
  assign wx      = XW'(w);
  assign w_plus7 = wx + XW'(7);
  assign w_plus1 = wx + XW'(1);

  always_comb begin
    unique case (cfg.pixel_format)
      bpr_pkg::FMT_1BPP:  bytes_lo = w_plus7[4:3];
      bpr_pkg::FMT_4BPP:  bytes_lo = w_plus1[2:1];
      bpr_pkg::FMT_8BPP:  bytes_lo = wx[1:0];
      bpr_pkg::FMT_BGR24: bytes_lo = 2'(wx[1:0] + {wx[0], 1'b0});
      default:            bytes_lo = 2'd0;
    endcase
  end

  assign pad_amt = 2'd0 - bytes_lo;

  assign emit_ok     = !pix_valid_r || pix_adv;
  assign in_ch.ready = !in_valid_r || in_take;

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    pad_nxt       = pad_r;
    phase_nxt     = phase_r;
    asm_nxt       = asm_r;
    done_nxt      = done_r;
    work_cnt_nxt  = work_cnt_r;
    work_pos_nxt  = work_pos_r;
    work_nib_nxt  = work_nib_r;
    work_byte_nxt = work_byte_r;
    in_take       = 1'b0;
    do_emit       = 1'b0;
    e_kind        = bpr_pkg::PIX_PAL;
    e_word        = '0;
    e_idx         = '0;
    e_last_run    = 1'b0;
    e_last_img    = 1'b0;
    c0            = col_r;
    r0            = row_r;
    c1            = '0;
    r1            = '0;
    diff          = '0;
    nrun          = '0;
    c0_next       = '0;
    pal_we        = 1'b0;

    if (work_cnt_r != '0) begin
      if (emit_ok) begin
        do_emit      = 1'b1;
        e_idx        = work_nib_r ? {4'h0, work_byte_r[3:0]}
                                  : {7'd0, work_byte_r[3'd7 - work_pos_r]};
        e_last_run   = (work_cnt_r == 3'd1);
        work_cnt_nxt = work_cnt_r - 3'd1;
        work_pos_nxt = work_pos_r + 3'd1;
      end
    end else if (in_valid_r && emit_ok) begin
      in_take = 1'b1;
      if (in_item_r.action == bpr_pkg::ACT_PALETTE) begin
        pal_we = (32'(in_item_r.palette_index) < PALETTE_DEPTH);
      end else if (!done_r && cfg.pixel_format <= bpr_pkg::FMT_MASK32) begin
        // width may have shrunk under a part-done row
        if (col_r >= w) begin
          c0 = '0;
          r0 = row_r + RW'(1);
        end
        col_nxt = c0;
        row_nxt = r0;
        if (r0 >= h) begin
          done_nxt = 1'b1;
        end else if (pad_r != '0) begin
          pad_nxt = pad_r - 2'd1;
        end else begin
          unique case (cfg.pixel_format)
            bpr_pkg::FMT_1BPP: begin
              diff          = DW'(w) - DW'(c0);
              nrun          = (diff >= DW'(8)) ? 4'd8 : {1'b0, diff[2:0]};
              do_emit       = 1'b1;
              e_idx         = {7'd0, in_item_r.data_byte[7]};
              e_last_run    = (nrun == 4'd1);
              work_cnt_nxt  = 3'(nrun - 4'd1);
              work_pos_nxt  = 3'd1;
              work_nib_nxt  = 1'b0;
              work_byte_nxt = in_item_r.data_byte;
            end
            bpr_pkg::FMT_4BPP: begin
              c0_next       = {1'b0, c0} + (CW+1)'(1);
              do_emit       = 1'b1;
              e_idx         = {4'h0, in_item_r.data_byte[7:4]};
              e_last_run    = !(c0_next < {1'b0, w});
              work_cnt_nxt  = (c0_next < {1'b0, w}) ? 3'd1 : 3'd0;
              work_pos_nxt  = 3'd1;
              work_nib_nxt  = 1'b1;
              work_byte_nxt = in_item_r.data_byte;
            end
            bpr_pkg::FMT_8BPP: begin
              do_emit    = 1'b1;
              e_idx      = in_item_r.data_byte;
              e_last_run = 1'b1;
            end
            bpr_pkg::FMT_BGR24: begin
              if (phase_r >= 2'd2) begin
                do_emit    = 1'b1;
                e_kind     = bpr_pkg::PIX_BGR;
                e_word     = {in_item_r.data_byte, asm_r};
                e_last_run = 1'b1;
                phase_nxt  = '0;
                asm_nxt    = '0;
              end else begin
                asm_nxt   = asm_r | (24'(in_item_r.data_byte) << {phase_r, 3'b000});
                phase_nxt = phase_r + 2'd1;
              end
            end
            bpr_pkg::FMT_MASK32: begin
              if (phase_r == 2'd3) begin
                do_emit    = 1'b1;
                e_kind     = bpr_pkg::PIX_MASK;
                e_word     = {in_item_r.data_byte, asm_r};
                e_last_run = 1'b1;
                phase_nxt  = '0;
                asm_nxt    = '0;
              end else begin
                asm_nxt   = asm_r | (24'(in_item_r.data_byte) << {phase_r, 3'b000});
                phase_nxt = phase_r + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end

    if (do_emit) begin
      c1 = c0 + CW'(1);
      r1 = r0 + RW'(1);
      if (c1 >= w) begin
        col_nxt = '0;
        row_nxt = r1;
        pad_nxt = pad_amt;
        if (r1 >= h) begin
          done_nxt   = 1'b1;
          pad_nxt    = '0;
          e_last_img = 1'b1;
        end
      end else begin
        col_nxt = c1;
      end
    end
  end

  assign e_pal_ok = (32'(e_idx) < PALETTE_DEPTH);
  assign row_out  = h - RW'(1) - r0;

  always_comb begin
    pix_nxt       = pix_r;
    pix_valid_nxt = pix_valid_r;
    if (do_emit) begin
      pix_nxt.kind     = e_kind;
      pix_nxt.pal_ok   = e_pal_ok;
      pix_nxt.word     = e_word;
      pix_nxt.column   = 14'(c0);
      pix_nxt.row      = 14'(row_out);
      pix_nxt.last_run = e_last_run;
      pix_nxt.last_img = e_last_img;
      pix_valid_nxt    = 1'b1;
    end else if (pix_adv) begin
      pix_valid_nxt = 1'b0;
    end
  end

  assign pal_waddr = in_item_r.palette_index[AW-1:0];
  assign pal_wdata = {in_item_r.palette_red, in_item_r.palette_green,
                      in_item_r.palette_blue};
  assign pal_re    = do_emit && (e_kind == bpr_pkg::PIX_PAL);
  assign pal_raddr = e_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      pad_r       <= '0;
      phase_r     <= '0;
      asm_r       <= '0;
      done_r      <= 1'b0;
      work_cnt_r  <= '0;
      pix_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pad_r       <= pad_nxt;
      phase_r     <= phase_nxt;
      asm_r       <= asm_nxt;
      done_r      <= done_nxt;
      work_cnt_r  <= work_cnt_nxt;
      pix_valid_r <= pix_valid_nxt;
      if (pal_we) begin
        vld_r[pal_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.action        <= in_ch.action;
      in_item_r.data_byte     <= in_ch.data_byte;
      in_item_r.palette_index <= in_ch.palette_index;
      in_item_r.palette_red   <= in_ch.palette_red;
      in_item_r.palette_green <= in_ch.palette_green;
      in_item_r.palette_blue  <= in_ch.palette_blue;
    end
    work_pos_r  <= work_pos_nxt;
    work_nib_r  <= work_nib_nxt;
    work_byte_r <= work_byte_nxt;
    pix_r       <= pix_nxt;
    if (pal_re) begin
      pal_vld_r <= vld_r[pal_raddr];
    end
  end

  assign pix       = pix_r;
  assign pix_valid = pix_valid_r;
  assign pal_vld   = pal_vld_r;

endmodule

// ===== sv/bpr_pixel_out.sv =====
module bpr_pixel_out (
  input  logic          clk,
  input  logic          rst_n,
  input  bpr_pkg::cfg_t cfg,
  input  bpr_pkg::pix_t pix,
  input  logic          pix_valid,
  output logic          pix_adv,
  input  logic [23:0]   pal_data,
  input  logic          pal_vld,
  bpr_out_if.source     out_ch
);

  logic        out_valid_r;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [13:0] column_r;
  logic [13:0] row_r;
  logic        last_run_r;
  logic        last_img_r;
  logic        err_r, err_nxt;
  logic [23:0] colour;
  logic        load;

  assign pix_adv = !out_valid_r || out_ch.ready;
  assign load    = pix_valid && pix_adv;
  assign colour  = (pix.pal_ok && pal_vld) ? pal_data : 24'd0;

  always_comb begin
    red_nxt   = colour[23:16];
    green_nxt = colour[15:8];
    blue_nxt  = colour[7:0];
    alpha_nxt = 8'd0;
    err_nxt   = 1'b0;
    unique case (pix.kind)
      bpr_pkg::PIX_BGR: begin
        red_nxt   = pix.word[31:24];
        green_nxt = pix.word[15:8];
        blue_nxt  = pix.word[7:0];
      end
      bpr_pkg::PIX_MASK: begin
        red_nxt   = 8'((pix.word & cfg.red_mask) >> cfg.red_shift);
        green_nxt = 8'((pix.word & cfg.green_mask) >> cfg.green_shift);
        blue_nxt  = 8'((pix.word & cfg.blue_mask) >> cfg.blue_shift);
        alpha_nxt = 8'((pix.word & cfg.alpha_mask) >> cfg.alpha_shift);
        err_nxt   = cfg.mask_err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
      alpha_r    <= alpha_nxt;
      column_r   <= pix.column;
      row_r      <= pix.row;
      last_run_r <= pix.last_run;
      last_img_r <= pix.last_img;
      err_r      <= err_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.red           = red_r;
  assign out_ch.green         = green_r;
  assign out_ch.blue          = blue_r;
  assign out_ch.alpha         = alpha_r;
  assign out_ch.column        = column_r;
  assign out_ch.row           = row_r;
  assign out_ch.last_of_run   = last_run_r;
  assign out_ch.last_of_image = last_img_r;
  assign out_ch.mask_error    = err_r;

endmodule

// ===== sv/bmp_pixel_row_decoder_top.sv =====
// Bitmap pixel-array decoder: takes pixel-array bytes or palette writes on in_ch and
// produces RGBA pixels with column and flipped row on out_ch. A byte of 8, 24 or 32 bpp
// data, a padding byte or a palette write flows at one item per cycle when out_ch does
// not stall. A 1 bpp byte occupies the decoder until each pixel it yields (up to 8) is
// emitted, and a 4 bpp byte likewise for up to 2 pixels, as each pixel takes its own
// access to the single read port of the palette RAM. A pixel passes from the input register
// through the pixel register to the output register on out_ch; these registers keep both
// sides moving under back-pressure. The palette has per-entry valid bits cleared by reset,
// so no clearing pass is needed.
module bmp_pixel_row_decoder_top #(
  parameter int MAX_WIDTH     = bpr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = bpr_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bpr_in_if.sink                     in_ch,
  bpr_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpr_pkg::CFG_AW-1:0] paddr,
  input  logic [bpr_pkg::CFG_DW-1:0] pwdata,
  output logic [bpr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  bpr_pkg::cfg_t cfg;
  bpr_pkg::pix_t pix;
  logic          pix_valid;
  logic          pix_adv;
  logic          pal_we;
  logic [AW-1:0] pal_waddr;
  logic [23:0]   pal_wdata;
  logic          pal_re;
  logic [AW-1:0] pal_raddr;
  logic [23:0]   pal_rdata;
  logic          pal_vld;

  bpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpr_emitter #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .pix_adv   (pix_adv),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pal_we    (pal_we),
    .pal_waddr (pal_waddr),
    .pal_wdata (pal_wdata),
    .pal_re    (pal_re),
    .pal_raddr (pal_raddr),
    .pal_vld   (pal_vld)
  );

  bpr_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  bpr_pixel_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_adv   (pix_adv),
    .pal_data  (pal_rdata),
    .pal_vld   (pal_vld),
    .out_ch    (out_ch)
  );

endmodule
